// ===== design/qpt_pkg.sv =====
// Shared types, register indexes and sizing constants for the quaternion point transform.
package qpt_pkg;

	// Coordinate width, fixed by the point and result beat layouts.
	localparam int COORD_W = 32;

	// Default width of one quaternion component.
	localparam int QUAT_W_DEF = 16;

	// Configuration port sizing.
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FWD_QUAT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_INV_QUAT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = CFG_IDX_W'(4);

	// Request type codes.
	localparam logic REQ_FORWARD = 1'b0;
	localparam logic REQ_INVERSE = 1'b1;

	// Cycles from an accepted start to the result strobe.
	localparam int PIPE_LAT = 6;

	typedef logic signed [COORD_W-1:0] coord_t;

	// One input beat.
	typedef struct packed {
		logic   req_type;
		coord_t point_x;
		coord_t point_y;
		coord_t point_z;
	} qpt_point_t;

	// One result beat.
	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
		coord_t out_z;
		logic   saturated;
	} qpt_result_t;

endpackage

// ===== design/quaternion_point_transform.sv =====
// Six-stage pipelined quaternion rotation of 3D points between two frames.
//
// Channel   Direction  Handshake                  Beat
// point     in         start high, busy low       qpt_point_t
// result    out        done high for one cycle    qpt_result_t
// cfg       in         cfg_we high                cfg_index, cfg_data
//
// One point is accepted every cycle; busy is never raised.
// From the accepting edge to done, a point passes through quaternion products,
// matrix entries, split partial products, product merge, row sums, and
// rounding with offset and saturation, each taking one register stage.
// Reset clears the valid bits and the configuration registers to zero.
// The receiver takes every result beat, so the pipeline never stalls.
module quaternion_point_transform
	import qpt_pkg::*;
#(
	parameter int QUAT_WIDTH = QUAT_W_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  qpt_point_t            point,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output qpt_result_t           result
);

	localparam int CW     = COORD_W;
	localparam int QW     = QUAT_WIDTH;
	localparam int QFRAC  = QW - 2;
	localparam int RSHIFT = 2 * QFRAC;
	localparam int PQ     = 2 * QW;        // component product
	localparam int MW     = 2 * QW + 2;    // matrix entry
	localparam int VW     = CW + 1;        // vector after offset subtraction
	localparam int VL     = (VW + 1) / 2;  // unsigned low slice of the vector
	localparam int VH     = VW - VL;       // signed high slice of the vector
	localparam int PLW    = MW + VL + 1;
	localparam int PHW    = MW + VH;
	localparam int PW     = MW + VW;       // full entry-times-coordinate product
	localparam int AW     = PW + 2;        // row sum
	localparam int RW     = AW - RSHIFT;   // rounded row
	localparam int FW     = RW + 1;        // rounded row plus offset

	localparam logic signed [MW-1:0] ONE_FX   = MW'(1) << RSHIFT;
	localparam logic signed [AW-1:0] HALF_FX  = AW'(1) << (RSHIFT - 1);
	localparam logic signed [FW-1:0] SAT_MAX  = FW'({1'b0, {(CW-1){1'b1}}});
	localparam logic signed [FW-1:0] SAT_MIN  = ~SAT_MAX;

	logic accept;

	// Configuration registers.
	logic [4*QW-1:0]        fwd_quat_q;
	logic [4*QW-1:0]        inv_quat_q;
	logic signed [CW-1:0]   off_q [3];

	// Stage 1: component products and the vector to rotate.
	logic                   valid_s1, mode_s1;
	logic signed [PQ-1:0]   xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic signed [VW-1:0]   v_s1 [3];

	// Stage 2: rotation matrix.
	logic                   valid_s2, mode_s2;
	logic signed [MW-1:0]   m_s2 [3][3];
	logic signed [VW-1:0]   v_s2 [3];

	// Stage 3: partial products on the split vector.
	logic                   valid_s3, mode_s3;
	logic signed [PLW-1:0]  plo_s3 [3][3];
	logic signed [PHW-1:0]  phi_s3 [3][3];

	// Stage 4: merged products.
	logic                   valid_s4, mode_s4;
	logic signed [PW-1:0]   prod_s4 [3][3];

	// Stage 5: row sums with the rounding half added.
	logic                   valid_s5, mode_s5;
	logic signed [AW-1:0]   acc_s5 [3];

	// Stage 6: output register.
	logic                   valid_s6;
	qpt_result_t            result_s6;

	// Stage 1 inputs.
	logic [4*QW-1:0]        quat_c;
	logic signed [QW-1:0]   qw_c, qx_c, qy_c, qz_c;
	logic signed [CW-1:0]   pt_c [3];
	logic signed [VW-1:0]   v_c [3];

	// Stage 2 and later combinational values.
	logic signed [MW-1:0]   m_c [3][3];
	logic signed [FW-1:0]   fin_c [3];
	logic signed [CW-1:0]   clip_c [3];
	logic [2:0]             sat_c;

	function automatic logic signed [MW-1:0] ext_p(input logic signed [PQ-1:0] a);
		return MW'(a);
	endfunction

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Configuration writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_quat_q <= '0;
			inv_quat_q <= '0;
			off_q[0]   <= '0;
			off_q[1]   <= '0;
			off_q[2]   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FWD_QUAT: fwd_quat_q <= cfg_data[4*QW-1:0];
				REG_INV_QUAT: inv_quat_q <= cfg_data[4*QW-1:0];
				REG_OFFSET_X: off_q[0]   <= cfg_data[CW-1:0];
				REG_OFFSET_Y: off_q[1]   <= cfg_data[CW-1:0];
				REG_OFFSET_Z: off_q[2]   <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// Pick the quaternion and form the vector: forward mode subtracts the offset first.
	always_comb begin
		quat_c = (point.req_type == REQ_INVERSE) ? inv_quat_q : fwd_quat_q;
		qw_c   = quat_c[4*QW-1 -: QW];
		qx_c   = quat_c[3*QW-1 -: QW];
		qy_c   = quat_c[2*QW-1 -: QW];
		qz_c   = quat_c[QW-1:0];
		pt_c[0] = point.point_x;
		pt_c[1] = point.point_y;
		pt_c[2] = point.point_z;
		for (int i = 0; i < 3; i++) begin
			if (point.req_type == REQ_INVERSE) begin
				v_c[i] = {pt_c[i][CW-1], pt_c[i]};
			end else begin
				v_c[i] = {pt_c[i][CW-1], pt_c[i]} - {off_q[i][CW-1], off_q[i]};
			end
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// Stage 1 register: the nine component products and the vector to rotate.
	always_ff @(posedge clk) begin
		mode_s1 <= point.req_type;
		xx_s1   <= qx_c * qx_c;
		yy_s1   <= qy_c * qy_c;
		zz_s1   <= qz_c * qz_c;
		xy_s1   <= qx_c * qy_c;
		xz_s1   <= qx_c * qz_c;
		yz_s1   <= qy_c * qz_c;
		wx_s1   <= qw_c * qx_c;
		wy_s1   <= qw_c * qy_c;
		wz_s1   <= qw_c * qz_c;
		for (int i = 0; i < 3; i++) begin
			v_s1[i] <= v_c[i];
		end
	end

	// Matrix entries from the products; a non-unit quaternion scales as it is.
	always_comb begin
		m_c[0][0] = ONE_FX - ((ext_p(yy_s1) + ext_p(zz_s1)) <<< 1);
		m_c[0][1] = (ext_p(xy_s1) - ext_p(wz_s1)) <<< 1;
		m_c[0][2] = (ext_p(xz_s1) + ext_p(wy_s1)) <<< 1;
		m_c[1][0] = (ext_p(xy_s1) + ext_p(wz_s1)) <<< 1;
		m_c[1][1] = ONE_FX - ((ext_p(xx_s1) + ext_p(zz_s1)) <<< 1);
		m_c[1][2] = (ext_p(yz_s1) - ext_p(wx_s1)) <<< 1;
		m_c[2][0] = (ext_p(xz_s1) - ext_p(wy_s1)) <<< 1;
		m_c[2][1] = (ext_p(yz_s1) + ext_p(wx_s1)) <<< 1;
		m_c[2][2] = ONE_FX - ((ext_p(xx_s1) + ext_p(yy_s1)) <<< 1);
	end

	// Stage 2 register.
	always_ff @(posedge clk) begin
		mode_s2 <= mode_s1;
		for (int i = 0; i < 3; i++) begin
			v_s2[i] <= v_s1[i];
			for (int j = 0; j < 3; j++) begin
				m_s2[i][j] <= m_c[i][j];
			end
		end
	end

	// Stage 3: each entry times the low and high halves of its coordinate.
	always_ff @(posedge clk) begin
		mode_s3 <= mode_s2;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				plo_s3[i][j] <= m_s2[i][j] * $signed({1'b0, v_s2[j][VL-1:0]});
				phi_s3[i][j] <= m_s2[i][j] * $signed(v_s2[j][VW-1:VL]);
			end
		end
	end

	// Stage 4: merge the halves into exact products.
	always_ff @(posedge clk) begin
		mode_s4 <= mode_s3;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod_s4[i][j] <= (PW'(phi_s3[i][j]) <<< VL) + PW'(plo_s3[i][j]);
			end
		end
	end

	// Stage 5: exact row sums, biased by one half for round to nearest, ties up.
	always_ff @(posedge clk) begin
		mode_s5 <= mode_s4;
		for (int i = 0; i < 3; i++) begin
			acc_s5[i] <= AW'(prod_s4[i][0]) + AW'(prod_s4[i][1]) + AW'(prod_s4[i][2])
				+ HALF_FX;
		end
	end

	// Drop the fraction, add the offset in inverse mode, then clip.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fin_c[i] = FW'($signed(acc_s5[i][AW-1:RSHIFT]));
			if (mode_s5 == REQ_INVERSE) begin
				fin_c[i] = fin_c[i] + FW'(off_q[i]);
			end
			if (fin_c[i] > SAT_MAX) begin
				clip_c[i] = SAT_MAX[CW-1:0];
				sat_c[i]  = 1'b1;
			end else if (fin_c[i] < SAT_MIN) begin
				clip_c[i] = SAT_MIN[CW-1:0];
				sat_c[i]  = 1'b1;
			end else begin
				clip_c[i] = fin_c[i][CW-1:0];
				sat_c[i]  = 1'b0;
			end
		end
	end

	// Stage 6: result register.
	always_ff @(posedge clk) begin
		result_s6.out_x     <= clip_c[0];
		result_s6.out_y     <= clip_c[1];
		result_s6.out_z     <= clip_c[2];
		result_s6.saturated <= |sat_c;
	end

	assign done   = valid_s6;
	assign result = result_s6;

endmodule

// ===== design/qpt_checker.sv =====
// Port-level checker for the quaternion point transform, bound to the top level.
module qpt_checker
	import qpt_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input qpt_result_t result
);

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	// Cycles since reset, held once the pipeline depth is reached.
	logic [$clog2(PIPE_LAT+1)-1:0] age_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (age_q != ($clog2(PIPE_LAT+1))'(PIPE_LAT)) begin
			age_q <= age_q + 1'b1;
		end
	end

	// The block always takes a start beat.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// Every accepted beat gives a result after the pipeline latency.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LAT done)
		else $error("result missing after accepted beat");

	// No result beat without a matching accepted beat.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (age_q == ($clog2(PIPE_LAT+1))'(PIPE_LAT))
			&& $past(start && !busy, PIPE_LAT))
		else $error("result beat without an accepted beat");

	// A saturated flag means some coordinate sits at a range limit.
	a_sat_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.saturated) |->
			(result.out_x == COORD_MAX || result.out_x == COORD_MIN
			|| result.out_y == COORD_MAX || result.out_y == COORD_MIN
			|| result.out_z == COORD_MAX || result.out_z == COORD_MIN))
		else $error("saturated flag without a clipped coordinate");

endmodule

bind quaternion_point_transform qpt_checker u_qpt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
